@@ src/ctpc_pkg.sv @@
package ctpc_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        ACT_SYNC_COUNT    = 3'd0,
        ACT_READ_COUNT    = 3'd1,
        ACT_WRITE_COUNT   = 3'd2,
        ACT_WRITE_COMPARE = 3'd3,
        ACT_SYNC_PERF     = 3'd4,
        ACT_RECORD_EVENTS = 3'd5,
        ACT_READ_PERF     = 3'd6,
        ACT_WRITE_PERF    = 3'd7
    } action_t;

    // Status bits
    localparam int ST_EXL_BIT = 1;
    localparam int ST_ERL_BIT = 2;

    // Performance control layout
    localparam int          PC_ENABLE_BIT = 31;
    localparam logic [31:0] PC_WMASK      = 32'h800f_fbfe;
    localparam logic [3:0]  CTR1_BASE     = 4'd10;
    localparam int          CTR0_EVT_LSB  = 5;
    localparam int          CTR1_EVT_LSB  = 15;

    // Event codes
    localparam logic [4:0] EV_LOW_BRANCH = 5'd0;
    localparam logic [4:0] EV_CYCLES     = 5'd1;
    localparam logic [4:0] EV_ISSUE      = 5'd2;
    localparam logic [4:0] EV_BRANCH     = 5'd3;
    localparam logic [4:0] EV_DONE       = 5'd12;
    localparam logic [4:0] EV_NON_BDS    = 5'd13;
    localparam logic [4:0] EV_COP        = 5'd14;
    localparam logic [4:0] EV_MEM        = 5'd15;

    localparam logic [31:0] OVF_SPAN = 32'h8000_0000;
    localparam logic [32:0] WRAP_SPAN = 33'h1_0000_0000;

    // Post-request snapshot handed to the deadline stage
    typedef struct packed {
        logic [31:0] read_data;
        logic        write_accepted;
        logic        timer_raised;
        logic [1:0]  overflow_mask;
        logic        timer_pending;
        logic        perf_exc;
        logic        timer_valid;
        logic [63:0] count_sync;
        logic [32:0] timer_dist;
        logic [63:0] now;
        logic [1:0]  cand_en;
        logic [63:0] perf_sync0;
        logic [63:0] perf_sync1;
        logic [31:0] rem0;
        logic [31:0] rem1;
    } snap_t;

endpackage

@@ src/cop0_timer_and_perf_counters_unit.sv @@
// Channel | dir | tdata fields (lowest bit up)
// s_      | in  | action 3, current_cycle 64, minimum_increment 1, status_mode 5,
//         |     | selector 6, write_value 32, event_strobes 11 (122 bits in 128)
// m_      | out | read_data 32, write_accepted 1, timer_raised 1, overflow_mask 2,
//         |     | timer_pending 1, perf_exception_pending 1, next_timer_valid 1,
//         |     | next_timer_cycle 64, next_perf_valid 1, next_perf_cycle 64 (168 bits)
//
// One request per cycle sustained while m_ accepts. Stages: input register,
// state update into the snapshot register, deadline adds into the result
// register. The state update stage is the only loop: each request sees the
// state left by the previous one. Synchronous active-low reset clears all
// timer and counter state and empties the pipe; no clearing pass. A stalled
// m_ side backs up stage by stage and drops s_tready only once all three are full.
module cop0_timer_and_perf_counters_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, current_cycle, minimum_increment, status_mode, selector,
    // write_value, event_strobes
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data, write_accepted, timer_raised, overflow_mask, timer_pending,
    // perf_exception_pending, next_timer_valid, next_timer_cycle,
    // next_perf_valid, next_perf_cycle
    output logic [167:0] m_tdata
);

    // ---------------------------------------------------------------- pipe control
    logic         in_valid_reg;
    logic [121:0] in_data_reg;
    logic         mid_valid_reg;
    ctpc_pkg::snap_t mid_reg;
    ctpc_pkg::snap_t mid_next;
    logic         out_valid_reg;
    logic [167:0] out_data_reg;
    logic [167:0] out_data_next;

    logic adv_out;
    logic adv_mid;

    assign adv_out  = mid_valid_reg && (!out_valid_reg || m_tready);
    assign adv_mid  = in_valid_reg && (!mid_valid_reg || adv_out);
    assign s_tready = !in_valid_reg || adv_mid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------- architectural state
    logic [31:0] count_reg,        count_next;
    logic [31:0] compare_reg,      compare_next;
    logic [31:0] perf_control_reg, perf_control_next;
    logic [31:0] perf_counter_reg [2];
    logic [31:0] perf_counter_next [2];
    logic [63:0] count_sync_reg,   count_sync_next;
    logic [63:0] perf_sync_reg [2];
    logic [63:0] perf_sync_next [2];
    logic        timer_armed_reg,  timer_armed_next;
    logic        timer_flag_reg,   timer_flag_next;

    // per-mode enable bit of a counter
    function automatic logic ctr_enable(input logic [31:0] ctrl, input logic c,
                                        input logic [4:0] status);
        logic [3:0] idx;
        idx = (c ? ctpc_pkg::CTR1_BASE : 4'd0)
            + (status[ctpc_pkg::ST_EXL_BIT] ? 4'd1 : 4'd2 + {2'b00, status[4:3]});
        return ctrl[idx];
    endfunction

    function automatic logic [4:0] ctr_event(input logic [31:0] ctrl, input logic c);
        return c ? ctrl[ctpc_pkg::CTR1_EVT_LSB +: 5] : ctrl[ctpc_pkg::CTR0_EVT_LSB +: 5];
    endfunction

    function automatic logic event_hit(input logic c, input logic [4:0] ev,
                                       input logic [10:0] s);
        logic hit;
        case (ev)
            ctpc_pkg::EV_LOW_BRANCH: hit = c & s[0];
            ctpc_pkg::EV_ISSUE:      hit = c ? s[2] : s[1];
            ctpc_pkg::EV_BRANCH:     hit = c ? s[4] : s[3];
            ctpc_pkg::EV_DONE:       hit = s[5];
            ctpc_pkg::EV_NON_BDS:    hit = s[6];
            ctpc_pkg::EV_COP:        hit = c ? s[8] : s[7];
            ctpc_pkg::EV_MEM:        hit = c ? s[10] : s[9];
            default:                 hit = 1'b0;
        endcase
        return hit;
    endfunction

    // ---------------------------------------------------------------- state update stage
    always_comb begin
        ctpc_pkg::action_t action;
        logic [63:0] now;
        logic        min_inc;
        logic [4:0]  status;
        logic [5:0]  sel;
        logic [31:0] val;
        logic [10:0] strobes;
        logic [63:0] cnt_el;
        logic        cnt_min;
        logic [63:0] cnt_inc;
        logic [31:0] cnt_diff;
        logic [32:0] cnt_dist;
        logic        cnt_raise;
        logic        allowed_old;
        logic        psync_min;
        logic        sync_perf_do;
        logic        record_do;
        logic [63:0] p_el [2];
        logic [63:0] bump_inc [2];
        logic [31:0] bumped [2];
        logic [1:0]  bump_mask;
        logic [31:0] rem_old;
        logic        ovf;
        logic [30:0] newlow;
        logic        allowed_new;
        logic [31:0] diff_new;

        action  = ctpc_pkg::action_t'(in_data_reg[2:0]);
        now     = in_data_reg[66:3];
        min_inc = in_data_reg[67];
        status  = in_data_reg[72:68];
        sel     = in_data_reg[78:73];
        val     = in_data_reg[110:79];
        strobes = in_data_reg[121:111];

        count_next           = count_reg;
        compare_next         = compare_reg;
        perf_control_next    = perf_control_reg;
        perf_counter_next[0] = perf_counter_reg[0];
        perf_counter_next[1] = perf_counter_reg[1];
        count_sync_next      = count_sync_reg;
        perf_sync_next[0]    = perf_sync_reg[0];
        perf_sync_next[1]    = perf_sync_reg[1];
        timer_armed_next     = timer_armed_reg;
        timer_flag_next      = timer_flag_reg;
        mid_next             = '0;

        // Count advance; time going backwards counts as nothing
        cnt_el   = (now >= count_sync_reg) ? now - count_sync_reg : 64'd0;
        cnt_min  = (action == ctpc_pkg::ACT_READ_COUNT)
                || (action == ctpc_pkg::ACT_SYNC_COUNT && min_inc);
        cnt_inc  = (cnt_min && cnt_el == 64'd0) ? 64'd1 : cnt_el;
        cnt_diff = compare_reg - count_reg;
        cnt_dist = (cnt_diff != 32'd0) ? {1'b0, cnt_diff} : ctpc_pkg::WRAP_SPAN;
        cnt_raise = (cnt_inc != 64'd0) && timer_armed_reg && !timer_flag_reg
                 && (cnt_inc >= {31'd0, cnt_dist});

        // Performance counters
        allowed_old  = !status[ctpc_pkg::ST_ERL_BIT]
                    && perf_control_reg[ctpc_pkg::PC_ENABLE_BIT];
        psync_min    = (action == ctpc_pkg::ACT_SYNC_PERF) ? min_inc : 1'b1;
        sync_perf_do = (action == ctpc_pkg::ACT_SYNC_PERF)
                    || (action == ctpc_pkg::ACT_READ_PERF && sel[0])
                    || (action == ctpc_pkg::ACT_WRITE_PERF && sel == 6'd0);
        record_do    = (action == ctpc_pkg::ACT_RECORD_EVENTS);

        for (int c = 0; c < 2; c++) begin
            p_el[c] = (now >= perf_sync_reg[c]) ? now - perf_sync_reg[c] : 64'd0;
            bump_inc[c] = 64'd0;
            if (allowed_old && ctr_enable(perf_control_reg, c[0], status)) begin
                if (sync_perf_do && ctr_event(perf_control_reg, c[0]) == ctpc_pkg::EV_CYCLES) begin
                    bump_inc[c] = (psync_min && p_el[c] == 64'd0) ? 64'd1 : p_el[c];
                end else if (record_do) begin
                    bump_inc[c] = {63'd0,
                        event_hit(c[0], ctr_event(perf_control_reg, c[0]), strobes)};
                end
            end
            // 31-bit count with sticky overflow on top; exact for huge advances
            rem_old = ctpc_pkg::OVF_SPAN - {1'b0, perf_counter_reg[c][30:0]};
            ovf     = bump_inc[c] >= {32'd0, rem_old};
            newlow  = perf_counter_reg[c][30:0] + bump_inc[c][30:0];
            if (bump_inc[c] != 64'd0) begin
                bumped[c]    = {perf_counter_reg[c][31] | ovf, newlow};
                bump_mask[c] = !perf_counter_reg[c][31] && ovf;
            end else begin
                bumped[c]    = perf_counter_reg[c];
                bump_mask[c] = 1'b0;
            end
        end

        if (sync_perf_do || record_do) begin
            perf_counter_next[0]   = bumped[0];
            perf_counter_next[1]   = bumped[1];
            mid_next.overflow_mask = bump_mask;
        end
        if (sync_perf_do) begin
            perf_sync_next[0] = now;
            perf_sync_next[1] = now;
        end

        unique case (action)
            ctpc_pkg::ACT_SYNC_COUNT, ctpc_pkg::ACT_READ_COUNT: begin
                count_next            = count_reg + cnt_inc[31:0];
                count_sync_next       = now;
                timer_flag_next       = timer_flag_reg | cnt_raise;
                mid_next.timer_raised = cnt_raise;
                if (action == ctpc_pkg::ACT_READ_COUNT) begin
                    mid_next.read_data = count_next;
                end
            end
            ctpc_pkg::ACT_WRITE_COUNT: begin
                count_next      = val;
                count_sync_next = now;
            end
            ctpc_pkg::ACT_WRITE_COMPARE: begin
                // any raise from this catch-up is dropped by the re-arm
                count_next       = count_reg + cnt_inc[31:0];
                count_sync_next  = now;
                compare_next     = val;
                timer_armed_next = 1'b1;
                timer_flag_next  = 1'b0;
            end
            ctpc_pkg::ACT_SYNC_PERF, ctpc_pkg::ACT_RECORD_EVENTS: begin
            end
            ctpc_pkg::ACT_READ_PERF: begin
                mid_next.read_data = sel[0] ? bumped[sel[1]] : perf_control_reg;
            end
            ctpc_pkg::ACT_WRITE_PERF: begin
                if (sel[0]) begin
                    perf_counter_next[sel[1]] = val;
                    perf_sync_next[sel[1]]    = now;
                    mid_next.write_accepted   = 1'b1;
                end else if (sel == 6'd0) begin
                    perf_control_next       = val & ctpc_pkg::PC_WMASK;
                    mid_next.write_accepted = 1'b1;
                end
            end
        endcase

        // Snapshot of post-request state for the deadline stage
        allowed_new = !status[ctpc_pkg::ST_ERL_BIT]
                   && perf_control_next[ctpc_pkg::PC_ENABLE_BIT];
        diff_new    = compare_next - count_next;
        mid_next.timer_pending = timer_flag_next;
        mid_next.perf_exc      = allowed_new
                              && (perf_counter_next[0][31] || perf_counter_next[1][31]);
        mid_next.timer_valid   = timer_armed_next && !timer_flag_next;
        mid_next.count_sync    = count_sync_next;
        mid_next.timer_dist    = (diff_new != 32'd0) ? {1'b0, diff_new} : ctpc_pkg::WRAP_SPAN;
        mid_next.now           = now;
        for (int c = 0; c < 2; c++) begin
            mid_next.cand_en[c] = allowed_new && ctr_enable(perf_control_next, c[0], status)
                               && ctr_event(perf_control_next, c[0]) == ctpc_pkg::EV_CYCLES;
        end
        mid_next.perf_sync0 = perf_sync_next[0];
        mid_next.perf_sync1 = perf_sync_next[1];
        mid_next.rem0 = ctpc_pkg::OVF_SPAN - {1'b0, perf_counter_next[0][30:0]};
        mid_next.rem1 = ctpc_pkg::OVF_SPAN - {1'b0, perf_counter_next[1][30:0]};
    end

    // ---------------------------------------------------------------- deadline stage
    always_comb begin
        logic [64:0] t_sum;
        logic [64:0] d0_sum;
        logic [64:0] d1_sum;
        logic [63:0] tcycle;
        logic [63:0] dl0;
        logic [63:0] dl1;
        logic        pvalid;
        logic [63:0] pcycle;

        // saturating adds: carry out means all ones
        t_sum  = {1'b0, mid_reg.count_sync} + {32'd0, mid_reg.timer_dist};
        d0_sum = {1'b0, mid_reg.perf_sync0} + {33'd0, mid_reg.rem0};
        d1_sum = {1'b0, mid_reg.perf_sync1} + {33'd0, mid_reg.rem1};
        dl0    = d0_sum[64] ? '1 : d0_sum[63:0];
        dl1    = d1_sum[64] ? '1 : d1_sum[63:0];
        tcycle = !mid_reg.timer_valid ? 64'd0 : (t_sum[64] ? '1 : t_sum[63:0]);

        if (mid_reg.perf_exc) begin
            // already overflowed: deadline is now
            pvalid = 1'b1;
            pcycle = mid_reg.now;
        end else begin
            pvalid = |mid_reg.cand_en;
            unique case (mid_reg.cand_en)
                2'b11:   pcycle = (dl1 < dl0) ? dl1 : dl0;
                2'b01:   pcycle = dl0;
                2'b10:   pcycle = dl1;
                default: pcycle = 64'd0;
            endcase
        end

        out_data_next = {pcycle, pvalid, tcycle, mid_reg.timer_valid, mid_reg.perf_exc,
                         mid_reg.timer_pending, mid_reg.overflow_mask,
                         mid_reg.timer_raised, mid_reg.write_accepted, mid_reg.read_data};
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            mid_valid_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
            count_reg           <= '0;
            compare_reg         <= '0;
            perf_control_reg    <= '0;
            perf_counter_reg[0] <= '0;
            perf_counter_reg[1] <= '0;
            count_sync_reg      <= '0;
            perf_sync_reg[0]    <= '0;
            perf_sync_reg[1]    <= '0;
            timer_armed_reg     <= 1'b0;
            timer_flag_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv_mid) begin
                mid_valid_reg <= 1'b1;
            end else if (adv_out) begin
                mid_valid_reg <= 1'b0;
            end
            if (adv_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (adv_mid) begin
                count_reg           <= count_next;
                compare_reg         <= compare_next;
                perf_control_reg    <= perf_control_next;
                perf_counter_reg[0] <= perf_counter_next[0];
                perf_counter_reg[1] <= perf_counter_next[1];
                count_sync_reg      <= count_sync_next;
                perf_sync_reg[0]    <= perf_sync_next[0];
                perf_sync_reg[1]    <= perf_sync_next[1];
                timer_armed_reg     <= timer_armed_next;
                timer_flag_reg      <= timer_flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[121:0];
        end
        if (adv_mid) begin
            mid_reg <= mid_next;
        end
        if (adv_out) begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------------------------------------------------------- assertions
    a_flag_moves_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(timer_flag_reg) |-> $past(adv_mid))
        else $error("timer flag set without a request");

    a_compare_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_mid && in_data_reg[2:0] == ctpc_pkg::ACT_WRITE_COMPARE
        |=> timer_armed_reg && !timer_flag_reg)
        else $error("compare write did not re-arm the timer");

    a_pending_excludes_deadline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[36] && m_tdata[38]))
        else $error("timer deadline reported while pending");

    a_idle_timer_deadline_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[38] |-> m_tdata[102:39] == 64'd0)
        else $error("timer deadline not zero when invalid");

    a_idle_perf_deadline_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[103] |-> m_tdata[167:104] == 64'd0)
        else $error("perf deadline not zero when invalid");

endmodule

@@ test/cop0_timer_and_perf_counters_unit_tb.sv @@
`timescale 1ns / 100ps

module cop0_timer_and_perf_counters_unit_tb;

    localparam int QUIET_LIMIT  = 1000;  // cycles without any handshake
    localparam int HOLD_AFTER   = 400;   // results before the long back-pressure hold
    localparam int HOLD_CYCLES  = 240;
    localparam int RANDOM_ITEMS = 1630;

    // One COP0 access or retire event
    typedef struct packed {
        logic [10:0]       strobes;
        logic [31:0]       wval;
        logic [5:0]        sel;
        logic [4:0]        status;
        logic              min_inc;
        logic [63:0]       cyc;
        ctpc_pkg::action_t action;
    } request_t;

    // Everything the block reports for one request
    typedef struct packed {
        logic [63:0] pcyc;
        logic        pvalid;
        logic [63:0] tcyc;
        logic        tvalid;
        logic        pexc;
        logic        tpend;
        logic [1:0]  omask;
        logic        raised;
        logic        acc;
        logic [31:0] rd;
    } result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // action, current_cycle, minimum_increment, status_mode, selector,
    // write_value, event_strobes
    logic [127:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // read_data, write_accepted, timer_raised, overflow_mask, timer_pending,
    // perf_exception_pending, next_timer_valid, next_timer_cycle,
    // next_perf_valid, next_perf_cycle
    logic [167:0] m_tdata;

    cop0_timer_and_perf_counters_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Mirror of the timer and counter state
    logic [31:0] cnt_q;
    logic [31:0] cmp_q;
    logic [31:0] pctl_q;
    logic [31:0] pctr_q [2];
    logic [63:0] cnt_ref_cyc;
    logic [63:0] pctr_ref_cyc [2];
    logic        tmr_armed;
    logic        tmr_pend;

    request_t pending_reqs [$];
    result_t  expected_results [$];
    request_t live_req;
    int       tx_gap       = 0;
    int       rx_stall     = 0;
    int       results_seen = 0;
    int       fail_count   = 0;
    int       quiet_cycles = 0;
    bit       tx_calm      = 1'b0;
    bit       rx_calm      = 1'b0;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Count steps to Compare; equal registers mean a full wrap
    function automatic logic [32:0] timer_gap();
        logic [31:0] d;
        d = cmp_q - cnt_q;
        return (d != 32'd0) ? {1'b0, d} : ctpc_pkg::WRAP_SPAN;
    endfunction

    function automatic logic count_advance(logic [63:0] now, logic min_inc);
        logic [63:0] el;
        logic        raised;
        raised = 1'b0;
        el = (now >= cnt_ref_cyc) ? now - cnt_ref_cyc : 64'd0;
        if (min_inc && el == 64'd0)
            el = 64'd1;
        if (el != 64'd0 && tmr_armed && !tmr_pend && el >= {31'b0, timer_gap()}) begin
            tmr_pend = 1'b1;
            raised   = 1'b1;
        end
        cnt_q       = cnt_q + el[31:0];
        cnt_ref_cyc = now;
        return raised;
    endfunction

    // EXL picks mode 1, else 2 + KSU; KSU of three lands on the event field lsb
    function automatic logic mode_enabled(int c, logic [4:0] status);
        int base;
        int mode;
        base = (c == 1) ? int'(ctpc_pkg::CTR1_BASE) : 0;
        mode = status[ctpc_pkg::ST_EXL_BIT] ? 1 : 2 + int'(status[4:3]);
        return pctl_q[base + mode];
    endfunction

    function automatic logic [4:0] sel_event(int c);
        return (c == 1) ? pctl_q[ctpc_pkg::CTR1_EVT_LSB +: 5]
                        : pctl_q[ctpc_pkg::CTR0_EVT_LSB +: 5];
    endfunction

    function automatic logic counting_on(logic [4:0] status);
        return !status[ctpc_pkg::ST_ERL_BIT] && pctl_q[ctpc_pkg::PC_ENABLE_BIT];
    endfunction

    // Overflow judged on the full 64-bit increment, so huge jumps never wrap past it
    function automatic logic [1:0] bump_counter(int c, logic [63:0] inc);
        logic [30:0] low;
        logic        was;
        logic        ovf;
        if (inc == 64'd0)
            return 2'b00;
        was       = pctr_q[c][31];
        low       = pctr_q[c][30:0];
        ovf       = inc >= ({32'b0, ctpc_pkg::OVF_SPAN} - {33'b0, low});
        pctr_q[c] = {was | ovf, low + inc[30:0]};
        return (!was && ovf) ? (2'b01 << c) : 2'b00;
    endfunction

    function automatic logic [1:0] perf_advance(logic [63:0] now, logic [4:0] status,
                                                logic min_inc);
        logic [1:0]  mask;
        logic [63:0] el;
        mask = 2'b00;
        for (int c = 0; c < 2; c++) begin
            el = (now >= pctr_ref_cyc[c]) ? now - pctr_ref_cyc[c] : 64'd0;
            if (counting_on(status) && mode_enabled(c, status) &&
                sel_event(c) == ctpc_pkg::EV_CYCLES) begin
                if (min_inc && el == 64'd0)
                    el = 64'd1;
                mask |= bump_counter(c, el);
            end
            pctr_ref_cyc[c] = now;
        end
        return mask;
    endfunction

    function automatic logic event_hit(int c, logic [4:0] ev, logic [10:0] s);
        case (ev)
            ctpc_pkg::EV_LOW_BRANCH: return (c == 1) ? s[0] : 1'b0;
            ctpc_pkg::EV_ISSUE:      return (c == 1) ? s[2] : s[1];
            ctpc_pkg::EV_BRANCH:     return (c == 1) ? s[4] : s[3];
            ctpc_pkg::EV_DONE:       return s[5];
            ctpc_pkg::EV_NON_BDS:    return s[6];
            ctpc_pkg::EV_COP:        return (c == 1) ? s[8] : s[7];
            ctpc_pkg::EV_MEM:        return (c == 1) ? s[10] : s[9];
            default:                 return 1'b0;
        endcase
    endfunction

    function automatic logic [1:0] record_strobes(logic [4:0] status, logic [10:0] s);
        logic [1:0] mask;
        mask = 2'b00;
        if (!counting_on(status))
            return mask;
        for (int c = 0; c < 2; c++)
            if (mode_enabled(c, status))
                mask |= bump_counter(c, {63'b0, event_hit(c, sel_event(c), s)});
        return mask;
    endfunction

    // Updates the mirrored state and returns what the block should report
    function automatic result_t apply_request(request_t r);
        result_t     o;
        logic [63:0] dl;
        o = '0;
        case (r.action)
            ctpc_pkg::ACT_SYNC_COUNT: o.raised = count_advance(r.cyc, r.min_inc);
            ctpc_pkg::ACT_READ_COUNT: begin
                o.raised = count_advance(r.cyc, 1'b1);
                o.rd     = cnt_q;
            end
            ctpc_pkg::ACT_WRITE_COUNT: begin
                cnt_q       = r.wval;
                cnt_ref_cyc = r.cyc;
            end
            ctpc_pkg::ACT_WRITE_COMPARE: begin
                // a raise caused by this sync is swallowed by the re-arm
                void'(count_advance(r.cyc, 1'b0));
                cmp_q     = r.wval;
                tmr_armed = 1'b1;
                tmr_pend  = 1'b0;
            end
            ctpc_pkg::ACT_SYNC_PERF:
                o.omask = perf_advance(r.cyc, r.status, r.min_inc);
            ctpc_pkg::ACT_RECORD_EVENTS:
                o.omask = record_strobes(r.status, r.strobes);
            ctpc_pkg::ACT_READ_PERF: begin
                if (!r.sel[0]) begin
                    o.rd = pctl_q;
                end else begin
                    o.omask = perf_advance(r.cyc, r.status, 1'b1);
                    o.rd    = pctr_q[r.sel[1]];
                end
            end
            default: begin
                if (!r.sel[0]) begin
                    if (r.sel == 6'd0) begin
                        o.omask = perf_advance(r.cyc, r.status, 1'b1);
                        pctl_q  = r.wval & ctpc_pkg::PC_WMASK;
                        o.acc   = 1'b1;
                    end
                end else begin
                    pctr_q[r.sel[1]]       = r.wval;
                    pctr_ref_cyc[r.sel[1]] = r.cyc;
                    o.acc                  = 1'b1;
                end
            end
        endcase

        o.tpend  = tmr_pend;
        o.tvalid = tmr_armed && !tmr_pend;
        if (o.tvalid)
            o.tcyc = sat_sum(cnt_ref_cyc, {31'b0, timer_gap()});

        if (counting_on(r.status)) begin
            if (pctr_q[0][31] | pctr_q[1][31]) begin
                o.pexc   = 1'b1;
                o.pvalid = 1'b1;
                o.pcyc   = r.cyc;
            end else begin
                for (int c = 0; c < 2; c++) begin
                    if (!mode_enabled(c, r.status) || sel_event(c) != ctpc_pkg::EV_CYCLES)
                        continue;
                    dl = sat_sum(pctr_ref_cyc[c],
                                 {32'b0, ctpc_pkg::OVF_SPAN} - {33'b0, pctr_q[c][30:0]});
                    if (!o.pvalid || dl < o.pcyc)
                        o.pcyc = dl;
                    o.pvalid = 1'b1;
                end
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] pack_request(request_t r);
        return {6'b0, r};
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(logic [167:0] raw);
        result_t got;
        result_t want;
        got = raw;
        if (expected_results.size() == 0) begin
            $error("result with no request outstanding: %h", raw);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("read_data", want.rd, got.rd);
        check_field("write_accepted", want.acc, got.acc);
        check_field("timer_raised", want.raised, got.raised);
        check_field("overflow_mask", want.omask, got.omask);
        check_field("timer_pending", want.tpend, got.tpend);
        check_field("perf_exception_pending", want.pexc, got.pexc);
        check_field("next_timer_valid", want.tvalid, got.tvalid);
        check_field("next_timer_cycle", want.tcyc, got.tcyc);
        check_field("next_perf_valid", want.pvalid, got.pvalid);
        check_field("next_perf_cycle", want.pcyc, got.pcyc);
    endtask

    task automatic queue_req(ctpc_pkg::action_t a, logic [63:0] cyc, logic mi,
                             logic [4:0] st, logic [5:0] sel, logic [31:0] v,
                             logic [10:0] stb);
        request_t r;
        r.action  = a;
        r.cyc     = cyc;
        r.min_inc = mi;
        r.status  = st;
        r.sel     = sel;
        r.wval    = v;
        r.strobes = stb;
        pending_reqs.push_back(r);
    endtask

    // Control word: enable, event and mode-enable fields for both counters
    function automatic logic [31:0] make_ctl(logic [4:0] ev0, logic [4:0] ev1,
                                             logic [3:0] en0, logic [3:0] en1, logic on);
        return {on, 11'b0, ev1, en1, 1'b0, ev0, en0, 1'b0};
    endfunction

    function automatic logic [4:0] pick_event();
        case ($urandom_range(0, 9))
            0:       return ctpc_pkg::EV_LOW_BRANCH;
            1, 2:    return ctpc_pkg::EV_CYCLES;
            3:       return ctpc_pkg::EV_ISSUE;
            4:       return ctpc_pkg::EV_BRANCH;
            5:       return ctpc_pkg::EV_DONE;
            6:       return ctpc_pkg::EV_NON_BDS;
            7:       return ctpc_pkg::EV_COP;
            8:       return ctpc_pkg::EV_MEM;
            default: return 5'($urandom);
        endcase
    endfunction

    // Near-overflow values make up half the picks so the sticky bit gets set often
    function automatic logic [31:0] pick_counter_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'h7fff_ffff - $urandom_range(0, 64);
            2:       return 32'hffff_ffff - $urandom_range(0, 64);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Request driver: one request in flight on s_, random gaps between requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(live_req));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    live_req = pending_reqs.pop_front();
                    s_tdata  <= pack_request(live_req);
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 40) == 0)
                        tx_calm = !tx_calm;
                    tx_gap   <= tx_calm ? 0 : $urandom_range(0, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stalls, plus one long hold to back the pipe up
    always @(posedge aclk) begin : result_monitor
        int stall_n;
        stall_n = rx_stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                results_seen++;
                if ($urandom_range(0, 40) == 0)
                    rx_calm = !rx_calm;
                stall_n = rx_calm ? 0 : $urandom_range(0, 17);
                if (results_seen == HOLD_AFTER)
                    stall_n = HOLD_CYCLES;
            end else if (stall_n > 0) begin
                stall_n--;
            end
            m_tready <= (stall_n == 0);
            rx_stall <= stall_n;
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0]       proc_cycle;
        logic [4:0]        st;
        logic [5:0]        sel;
        logic [31:0]       v;
        ctpc_pkg::action_t act;
        int                pick;

        cnt_q           = '0;
        cmp_q           = '0;
        pctl_q          = '0;
        pctr_q[0]       = '0;
        pctr_q[1]       = '0;
        cnt_ref_cyc     = '0;
        pctr_ref_cyc[0] = '0;
        pctr_ref_cyc[1] = '0;
        tmr_armed       = 1'b0;
        tmr_pend        = 1'b0;

        // Timer: wrap of Count, crossing Compare, no re-raise while pending,
        // cycle going backwards, Compare equal to Count
        queue_req(ctpc_pkg::ACT_READ_COUNT, 64'd0, 1'b0, 5'd0, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_COUNT, 64'd4, 1'b0, 5'd0, 6'd0, 32'hffff_fff0,
                  11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_COMPARE, 64'd6, 1'b0, 5'd0, 6'd0, 32'hffff_fffa,
                  11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_COUNT, 64'd10, 1'b0, 5'd0, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_COUNT, 64'd14, 1'b0, 5'd0, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_COUNT, 64'd14, 1'b1, 5'd0, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_COUNT, 64'd3, 1'b0, 5'd0, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_COUNT, 64'd20, 1'b0, 5'd0, 6'd0, 32'd77, 11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_COMPARE, 64'd20, 1'b0, 5'd0, 6'd0, 32'd77, 11'd0);
        queue_req(ctpc_pkg::ACT_READ_COUNT, 64'd21, 1'b0, 5'd0, 6'd0, 32'd0, 11'd0);
        // Control writes: rejected selector, all-ones value, then cycle counting
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd22, 1'b0, 5'd0, 6'd2, 32'hffff_ffff,
                  11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd23, 1'b0, 5'd0, 6'd0, 32'hffff_ffff,
                  11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd30, 1'b0, 5'd0, 6'd0,
                  make_ctl(ctpc_pkg::EV_CYCLES, ctpc_pkg::EV_CYCLES, 4'hf, 4'hf, 1'b1),
                  11'd0);
        // Counter writes, one with the overflow bit already set
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd31, 1'b0, 5'd0, 6'd1, 32'h7fff_fff0,
                  11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd31, 1'b0, 5'd0, 6'd3, 32'hffff_fff0,
                  11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_PERF, 64'd60, 1'b0, 5'd0, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_READ_PERF, 64'd61, 1'b0, 5'b11000, 6'd1, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_READ_PERF, 64'd62, 1'b0, 5'b11000, 6'd3, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_READ_PERF, 64'd62, 1'b0, 5'b11000, 6'd0, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_PERF, 64'd70, 1'b1, 5'b00100, 6'd0, 32'd0, 11'd0);
        // Cleared counters then a huge advance in exception mode
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd71, 1'b0, 5'd0, 6'd1, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'd71, 1'b0, 5'd0, 6'd3, 32'd0, 11'd0);
        queue_req(ctpc_pkg::ACT_SYNC_PERF, 64'h0000_0100_0000_0000, 1'b0, 5'b11010,
                  6'd0, 32'd0, 11'd0);
        // Event counting: memory on counter 0, low-order branch on counter 1
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'h0000_0100_0000_0001, 1'b0, 5'd0, 6'd0,
                  make_ctl(ctpc_pkg::EV_MEM, ctpc_pkg::EV_LOW_BRANCH, 4'hf, 4'hf, 1'b1),
                  11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_PERF, 64'h0000_0100_0000_0002, 1'b0, 5'd0, 6'd1,
                  32'd5, 11'd0);
        queue_req(ctpc_pkg::ACT_RECORD_EVENTS, 64'h0000_0100_0000_0003, 1'b0, 5'd0,
                  6'd0, 32'd0, 11'h7ff);
        queue_req(ctpc_pkg::ACT_RECORD_EVENTS, 64'h0000_0100_0000_0004, 1'b0, 5'd0,
                  6'd0, 32'd0, 11'h000);
        // Deadline saturation near the top of the cycle range
        queue_req(ctpc_pkg::ACT_WRITE_COUNT, 64'hffff_ffff_ffff_fff0, 1'b0, 5'd0, 6'd0,
                  32'd100, 11'd0);
        queue_req(ctpc_pkg::ACT_WRITE_COMPARE, 64'hffff_ffff_ffff_fff0, 1'b0, 5'd0,
                  6'd0, 32'd99, 11'd0);

        // Random part: mostly small forward steps so counts and timers actually
        // reach their deadlines, with the odd backward or huge jump
        proc_cycle = 64'd100;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                proc_cycle += $urandom_range(0, 24);
            else if (pick < 88)
                proc_cycle = proc_cycle;
            else if (pick < 92)
                proc_cycle -= $urandom_range(0, 30);
            else if (pick < 95)
                proc_cycle += $urandom_range(0, 1 << 20);
            else if (pick < 96)
                proc_cycle += {30'b0, 2'($urandom), 32'($urandom)};
            else if (pick < 98)
                proc_cycle = {32'($urandom), 32'($urandom)};
            else
                proc_cycle = 64'hffff_ffff_ffff_ffff - $urandom_range(0, 300);

            st = 5'($urandom);
            if ($urandom_range(0, 7) != 0)
                st[ctpc_pkg::ST_ERL_BIT] = 1'b0;
            sel = 6'($urandom);
            v   = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 12)       act = ctpc_pkg::ACT_SYNC_COUNT;
            else if (pick < 22)  act = ctpc_pkg::ACT_READ_COUNT;
            else if (pick < 28)  act = ctpc_pkg::ACT_WRITE_COUNT;
            else if (pick < 34)  act = ctpc_pkg::ACT_WRITE_COMPARE;
            else if (pick < 48)  act = ctpc_pkg::ACT_SYNC_PERF;
            else if (pick < 68)  act = ctpc_pkg::ACT_RECORD_EVENTS;
            else if (pick < 80)  act = ctpc_pkg::ACT_READ_PERF;
            else                 act = ctpc_pkg::ACT_WRITE_PERF;

            case (act)
                ctpc_pkg::ACT_WRITE_COUNT:
                    if ($urandom_range(0, 2) != 0) v = $urandom_range(0, 64);
                ctpc_pkg::ACT_WRITE_COMPARE:
                    if ($urandom_range(0, 2) != 0) v = $urandom_range(0, 160);
                ctpc_pkg::ACT_WRITE_PERF: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        sel = 6'd0;
                        v   = make_ctl(pick_event(), pick_event(),
                                       4'($urandom | $urandom), 4'($urandom | $urandom),
                                       $urandom_range(0, 7) != 0)
                              | ($urandom & ~ctpc_pkg::PC_WMASK);
                    end else if (pick < 8) begin
                        sel = 6'($urandom) | 6'd1;
                        v   = pick_counter_value();
                    end
                end
                default: ;
            endcase
            queue_req(act, proc_cycle, 1'($urandom), st, sel, v, 11'($urandom));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        // then wait on to catch any stray result
        repeat (8) @(posedge aclk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/ctpc_pkg.sv
src/cop0_timer_and_perf_counters_unit.sv
test/cop0_timer_and_perf_counters_unit_tb.sv
